// ===== src/bmorph_pkg.sv =====
package bmorph_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_RADIUS = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_OPERATION    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SE_SHAPE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SE_RADIUS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd4;

  localparam int RADIUS_W  = 2;
  localparam int FWIDTH_W  = 11;
  localparam int FHEIGHT_W = 13;
  localparam int ROW_W     = 12;

  localparam int HEIGHT_CAP = 4096;

  localparam logic                 OP_ERODE     = 1'b0;
  localparam logic                 OP_DILATE    = 1'b1;
  localparam logic                 SHAPE_SQUARE = 1'b0;
  localparam logic                 SHAPE_DISC   = 1'b1;
  localparam logic                 MODE_PIXEL   = 1'b0;
  localparam logic                 MODE_DRAIN   = 1'b1;

  localparam logic [RADIUS_W-1:0]  RST_RADIUS   = 2'd1;
  localparam logic [FWIDTH_W-1:0]  RST_FWIDTH   = 11'd640;
  localparam logic [FHEIGHT_W-1:0] RST_FHEIGHT  = 13'd480;

  localparam int SETTLE_W = 3;
  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 3'd4;

endpackage

// ===== src/bmorph_if.sv =====
interface bmorph_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic mask_bit;

  modport source (output valid, output mode, output mask_bit, input ready);
  modport sink (input valid, input mode, input mask_bit, output ready);
endinterface

interface bmorph_out_if;
  logic valid;
  logic ready;
  logic out_bit;
  logic out_last;

  modport source (output valid, output out_bit, output out_last, input ready);
  modport sink (input valid, input out_bit, input out_last, output ready);
endinterface

// ===== src/binary_morphology_window.sv =====
// Channel   Direction  Word fields          Handshake
// in_px     in         mode, mask_bit       valid/ready
// out_px    out        out_bit, out_last    valid/ready
// cfg_*     in         cfg_index, cfg_data  cfg_we, no back-pressure
//
// One word is taken per clock unless out_px stalls; results pass stage 1 and the output register.
// The rate is set by the read-modify-write of the column memory, one column word per cycle.
// After reset and after every configuration write, in_px.ready stays low until settle_r is zero.
// The column memory needs no clearing pass after reset.
// A waiting result blocks input only when a second result is already behind it.
module binary_morphology_window #(
  parameter int MAX_WIDTH  = bmorph_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = bmorph_pkg::DEF_MAX_RADIUS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  bmorph_in_if.sink                        in_px,
  bmorph_out_if.source                     out_px,
  input  logic                             cfg_we,
  input  logic [bmorph_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmorph_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_RADIUS + 1);
  localparam int K  = 2 * MAX_RADIUS + 1;
  localparam int KW = $clog2(K);
  localparam int SW = 2 * MAX_RADIUS;
  localparam int DW = $clog2(SW);
  localparam int PW = $clog2(MAX_WIDTH * bmorph_pkg::HEIGHT_CAP + 1);
  localparam int HW = bmorph_pkg::FHEIGHT_W;
  localparam int YW = bmorph_pkg::ROW_W;

  // Configuration registers.
  logic                             op_r;
  logic                             shape_r;
  logic [bmorph_pkg::RADIUS_W-1:0]  radius_r;
  logic [bmorph_pkg::FWIDTH_W-1:0]  fwidth_r;
  logic [bmorph_pkg::FHEIGHT_W-1:0] fheight_r;
  logic [bmorph_pkg::SETTLE_W-1:0]  settle_r, settle_nxt;

  // Derived geometry.
  logic [WW-1:0]    w_r, w_nxt;
  logic [HW-1:0]    h_r, h_nxt;
  logic [RW-1:0]    r_r, r_nxt;
  logic [K*K-1:0]   mask_r, mask_nxt;
  logic [PW-1:0]    n_r, n_nxt;
  logic [PW-1:0]    d_r, d_nxt;
  logic [PW-1:0]    nm1_r, nm1_nxt;

  // Frame counters.
  logic [PW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] in_col_r, in_col_nxt;
  logic [PW-1:0] out_pos_r, out_pos_nxt;
  logic [AW-1:0] out_col_r, out_col_nxt;
  logic [YW-1:0] out_row_r, out_row_nxt;

  // Stage 1.
  logic          s1_valid_r, s1_valid_nxt;
  logic          s1_px_r;
  logic          s1_emit_r;
  logic          s1_bit_r;
  logic [AW-1:0] s1_col_r;
  logic          s1_border_r;
  logic          s1_last_r;
  logic [DW-1:0] s1_depth_r;

  // Column memory and forwarding.
  logic [SW-1:0] col_mem [MAX_WIDTH];
  logic [SW-1:0] mem_q_r;
  logic          fwd_r;
  logic [SW-1:0] fwd_data_r;
  logic [SW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic          hit;
  logic [K-1:0]  col_full;
  logic [SW-1:0] wr_data;

  // Window.
  logic [K-1:0][K-1:0] window_r, win_nxt;
  logic [K*K-1:0]      win_flat;
  logic [KW-1:0]       cidx;

  // Output register.
  logic out_valid_r, out_valid_nxt;
  logic out_bit_r;
  logic out_last_r;

  // Item decode.
  logic          in_ready;
  logic          in_acc;
  logic          out_free;
  logic          s1_go;
  logic          out_load;
  logic          at_end;
  logic          is_px;
  logic          emit;
  logic          frame_done;
  logic [PW-1:0] lag;
  logic          border;
  logic [DW-1:0] depth;
  logic          restart;
  logic [WW:0]   x_sum;
  logic [HW-1:0] y_sum;
  logic          px_bit;
  logic          res_bit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r      <= bmorph_pkg::OP_ERODE;
      shape_r   <= bmorph_pkg::SHAPE_SQUARE;
      radius_r  <= bmorph_pkg::RST_RADIUS;
      fwidth_r  <= bmorph_pkg::RST_FWIDTH;
      fheight_r <= bmorph_pkg::RST_FHEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        bmorph_pkg::CFG_OPERATION:    op_r      <= cfg_data[0];
        bmorph_pkg::CFG_SE_SHAPE:     shape_r   <= cfg_data[0];
        bmorph_pkg::CFG_SE_RADIUS:    radius_r  <= cfg_data[bmorph_pkg::RADIUS_W-1:0];
        bmorph_pkg::CFG_FRAME_WIDTH:  fwidth_r  <= cfg_data[bmorph_pkg::FWIDTH_W-1:0];
        bmorph_pkg::CFG_FRAME_HEIGHT: fheight_r <= cfg_data[bmorph_pkg::FHEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    settle_nxt = settle_r;
    if (cfg_we) begin
      settle_nxt = bmorph_pkg::SETTLE_CYCLES;
    end else if (settle_r != '0) begin
      settle_nxt = settle_r - bmorph_pkg::SETTLE_W'(1);
    end
  end

  always_comb begin
    if (fwidth_r == '0) begin
      w_nxt = WW'(1);
    end else if (int'(fwidth_r) > MAX_WIDTH) begin
      w_nxt = WW'(MAX_WIDTH);
    end else begin
      w_nxt = WW'(fwidth_r);
    end
    if (fheight_r == '0) begin
      h_nxt = HW'(1);
    end else if (int'(fheight_r) > bmorph_pkg::HEIGHT_CAP) begin
      h_nxt = HW'(bmorph_pkg::HEIGHT_CAP);
    end else begin
      h_nxt = fheight_r;
    end
    if (int'(radius_r) > MAX_RADIUS) begin
      r_nxt = RW'(MAX_RADIUS);
    end else begin
      r_nxt = RW'(radius_r);
    end
  end

  always_comb begin
    int dy;
    int dx;
    int rv;
    rv = int'(r_r);
    for (int j = 0; j < K; j++) begin
      for (int i = 0; i < K; i++) begin
        dy = i - rv;
        dx = j - rv;
        mask_nxt[j*K+i] = (i <= 2 * rv) && (j <= 2 * rv) &&
                          ((shape_r == bmorph_pkg::SHAPE_SQUARE) || (dy * dy + dx * dx <= rv * rv));
      end
    end
  end

  assign n_nxt   = PW'(w_r) * PW'(h_r);
  assign d_nxt   = PW'(r_r) * PW'(w_r) + PW'(r_r);
  assign nm1_nxt = n_r - PW'(1);

  always_ff @(posedge clk) begin
    w_r    <= w_nxt;
    h_r    <= h_nxt;
    r_r    <= r_nxt;
    mask_r <= mask_nxt;
    n_r    <= n_nxt;
    d_r    <= d_nxt;
    nm1_r  <= nm1_nxt;
  end

  assign out_free = !out_valid_r || out_px.ready;
  assign s1_go    = s1_valid_r && (!s1_emit_r || out_free);
  assign in_ready = (settle_r == '0) && (!s1_valid_r || s1_go);
  assign in_acc   = in_px.valid && in_ready;
  assign out_load = s1_go && s1_emit_r;

  assign at_end     = (cnt_r == n_r);
  assign is_px      = (in_px.mode == bmorph_pkg::MODE_PIXEL) && !at_end;
  assign lag        = cnt_r - out_pos_r;
  assign emit       = is_px ? (lag >= d_r) : at_end;
  assign frame_done = emit && (out_pos_r == nm1_r);

  assign x_sum  = (WW+1)'(out_col_r) + (WW+1)'(r_r);
  assign y_sum  = HW'(out_row_r) + HW'(r_r);
  assign border = (r_r == '0) || ((WW+1)'(out_col_r) < (WW+1)'(r_r)) ||
                  (x_sum >= (WW+1)'(w_r)) || (HW'(out_row_r) < HW'(r_r)) || (y_sum >= h_r);
  assign depth  = DW'(h_r - HW'(1) - HW'(out_row_r));

  assign restart = (cnt_r > n_r) || (out_pos_r > cnt_r) || (out_pos_r >= n_r) ||
                   (WW'(in_col_r) >= w_r) || (WW'(out_col_r) >= w_r) ||
                   (HW'(out_row_r) >= h_r);

  always_comb begin
    cnt_nxt     = cnt_r;
    in_col_nxt  = in_col_r;
    out_pos_nxt = out_pos_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (in_acc) begin
      if (is_px) begin
        cnt_nxt = cnt_r + PW'(1);
        if (WW'(in_col_r) == w_r - WW'(1)) begin
          in_col_nxt = '0;
        end else begin
          in_col_nxt = in_col_r + AW'(1);
        end
      end
      if (emit) begin
        out_pos_nxt = out_pos_r + PW'(1);
        if (WW'(out_col_r) == w_r - WW'(1)) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + YW'(1);
        end else begin
          out_col_nxt = out_col_r + AW'(1);
        end
      end
      if (frame_done) begin
        cnt_nxt     = '0;
        in_col_nxt  = '0;
        out_pos_nxt = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end
    end else if ((settle_r == bmorph_pkg::SETTLE_W'(1)) && restart) begin
      cnt_nxt     = '0;
      in_col_nxt  = '0;
      out_pos_nxt = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_px.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r    <= bmorph_pkg::SETTLE_CYCLES;
      cnt_r       <= '0;
      in_col_r    <= '0;
      out_pos_r   <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      window_r    <= '0;
    end else begin
      settle_r    <= settle_nxt;
      cnt_r       <= cnt_nxt;
      in_col_r    <= in_col_nxt;
      out_pos_r   <= out_pos_nxt;
      out_col_r   <= out_col_nxt;
      out_row_r   <= out_row_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (mem_we) begin
        window_r <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r     <= is_px;
      s1_emit_r   <= emit;
      s1_bit_r    <= in_px.mask_bit;
      s1_col_r    <= rd_addr;
      s1_border_r <= border;
      s1_last_r   <= (out_pos_r == nm1_r);
      s1_depth_r  <= depth;
    end
    if (out_load) begin
      out_bit_r  <= res_bit;
      out_last_r <= s1_last_r;
    end
  end

  // Each column word holds the previous rows at that column, newest row in bit 0.
  assign rd_addr  = is_px ? in_col_r : out_col_r;
  assign mem_we   = s1_go && s1_px_r;
  assign rd_data  = fwd_r ? fwd_data_r : mem_q_r;
  assign col_full = {rd_data, s1_bit_r};
  assign wr_data  = col_full[SW-1:0];
  assign hit      = mem_we && (s1_col_r == rd_addr);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      col_mem[s1_col_r] <= wr_data;
    end
    if (in_acc) begin
      mem_q_r <= col_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fwd_r      <= hit;
      fwd_data_r <= wr_data;
    end
  end

  assign win_nxt  = {window_r[K-2:0], col_full};
  assign win_flat = win_nxt;
  assign cidx     = KW'(r_r);

  always_comb begin
    if (s1_border_r) begin
      px_bit = win_nxt[cidx][cidx];
    end else if (op_r == bmorph_pkg::OP_DILATE) begin
      px_bit = |(mask_r & win_flat);
    end else begin
      px_bit = &(~mask_r | win_flat);
    end
    res_bit = s1_px_r ? px_bit : rd_data[s1_depth_r];
  end

  assign in_px.ready     = in_ready;
  assign out_px.valid    = out_valid_r;
  assign out_px.out_bit  = out_bit_r;
  assign out_px.out_last = out_last_r;

  a_counter_order: assert property (@(posedge clk) disable iff (!rst_n)
    (settle_r == '0) |-> ((out_pos_r <= cnt_r) && (cnt_r <= n_r)))
    else $error("output position ahead of input count or count beyond frame");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && frame_done) |=> ((cnt_r == '0) && (out_pos_r == '0) && (in_col_r == '0)))
    else $error("counters not cleared after the last word of a frame");

endmodule
